// ===== hdl/nsf_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Shared constants, codes and structures for the slot pool framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

  // Pool geometry
  localparam int SLOTS     = 8;
  localparam int MSG_BYTES = 128;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADDR_W    = $clog2(SLOTS * MSG_BYTES);
  localparam int MASK_N    = (SLOTS < 8) ? SLOTS : 8;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int SEL_W  = 3;
  localparam int OFF_W  = 7;
  localparam int EV_W   = 4;
  localparam int LEN_W  = 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // Framing characters
  localparam logic [BYTE_W-1:0] START_CHAR = 8'h24;
  localparam logic [BYTE_W-1:0] END_CHAR   = 8'h0A;

  // Slot status codes
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_FILLING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Event codes
  localparam logic [EV_W-1:0] EV_IGNORED  = 4'd0;
  localparam logic [EV_W-1:0] EV_STARTED  = 4'd1;
  localparam logic [EV_W-1:0] EV_NO_SLOT  = 4'd2;
  localparam logic [EV_W-1:0] EV_STORED   = 4'd3;
  localparam logic [EV_W-1:0] EV_OVERFLOW = 4'd4;
  localparam logic [EV_W-1:0] EV_COMPLETE = 4'd5;
  localparam logic [EV_W-1:0] EV_EMPTY    = 4'd6;
  localparam logic [EV_W-1:0] EV_RELEASED = 4'd7;
  localparam logic [EV_W-1:0] EV_REJECTED = 4'd8;
  localparam logic [EV_W-1:0] EV_READ     = 4'd9;

  // Result of one command, without the store data
  typedef struct packed {
    logic [EV_W-1:0]  event_res;
    logic [SEL_W-1:0] event_slot;
    logic [LEN_W-1:0] length;
    logic [7:0]       full_mask;
    logic             rd_hit;
  } result_t;

  // Frame store access for one command
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== hdl/nsf_in_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one framer command per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nsf_in_if
  import nsf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] byte_value;
  logic [SEL_W-1:0]  slot;
  logic [OFF_W-1:0]  offset;

  modport source (output valid, command, byte_value, slot, offset, input ready);
  modport sink   (input valid, command, byte_value, slot, offset, output ready);
endinterface

`default_nettype wire

// ===== hdl/nsf_out_if.sv =====
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one framer event per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nsf_out_if
  import nsf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_res;
  logic [SEL_W-1:0]  event_slot;
  logic [LEN_W-1:0]  length;
  logic [BYTE_W-1:0] data;
  logic [7:0]        full_mask;

  modport source (output valid, event_res, event_slot, length, data, full_mask,
                  input ready);
  modport sink   (input valid, event_res, event_slot, length, data, full_mask,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/nsf_frame_ram.sv =====
// ----------------------------------------------------------------------------
// Frame store
// One write port, one read port, registered read data; all slots back to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsf_frame_ram
  import nsf_pkg::*;
(
  input  wire logic              clk,
  input  wire ram_req_t          req,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [SLOTS*MSG_BYTES];

  // Write received bytes
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nsf_slot_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot controller
// Holds slot status, lengths and framing state; decodes commands and issues
// frame store accesses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsf_slot_ctrl
  import nsf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [BYTE_W-1:0] byte_value,
  input  wire logic [SEL_W-1:0]  slot,
  input  wire logic [OFF_W-1:0]  offset,
  output result_t                res,
  output ram_req_t               ram_req
);

  logic [1:0]        slot_status      [SLOTS];
  logic [1:0]        slot_status_next [SLOTS];
  logic [LEN_W-1:0]  slot_length      [SLOTS];
  logic [LEN_W-1:0]  slot_length_next [SLOTS];
  logic              in_frame, in_frame_next;
  logic [SLOT_W-1:0] current_slot, current_slot_next;
  logic [LEN_W-1:0]  byte_count, byte_count_next;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              slot_ok;
  logic [SLOT_W-1:0] sidx;

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!free_found && slot_status[i] == ST_FREE) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign slot_ok = (32'(slot) < SLOTS);
  assign sidx    = slot_ok ? SLOT_W'(slot) : '0;

  // Decode the command
  always_comb begin
    slot_status_next  = slot_status;
    slot_length_next  = slot_length;
    in_frame_next     = in_frame;
    current_slot_next = current_slot;
    byte_count_next   = byte_count;
    res               = '0;
    res.event_res     = EV_IGNORED;
    ram_req           = '0;
    ram_req.waddr     = ADDR_W'(32'(current_slot) * MSG_BYTES + 32'(byte_count));
    ram_req.wdata     = byte_value;
    ram_req.raddr     = ADDR_W'(32'(sidx) * MSG_BYTES + 32'(offset));

    unique case (command)
      CMD_BYTE: begin
        if (!in_frame) begin
          if (byte_value == START_CHAR) begin
            if (free_found) begin
              slot_status_next[free_idx] = ST_FILLING;
              slot_length_next[free_idx] = '0;
              current_slot_next          = free_idx;
              byte_count_next            = '0;
              in_frame_next              = 1'b1;
              res.event_res              = EV_STARTED;
              res.event_slot             = SEL_W'(free_idx);
            end else begin
              res.event_res = EV_NO_SLOT;
            end
          end
        end else begin
          res.event_slot = SEL_W'(current_slot);
          if (byte_value == END_CHAR) begin
            if (byte_count == '0) begin
              slot_status_next[current_slot] = ST_FREE;
              slot_length_next[current_slot] = '0;
              res.event_res                  = EV_EMPTY;
            end else begin
              slot_status_next[current_slot] = ST_FULL;
              slot_length_next[current_slot] = byte_count;
              res.event_res                  = EV_COMPLETE;
              res.length                     = byte_count;
            end
            in_frame_next   = 1'b0;
            byte_count_next = '0;
          end else if (32'(byte_count) < MSG_BYTES) begin
            ram_req.we      = accept;
            byte_count_next = byte_count + LEN_W'(1);
            res.event_res   = EV_STORED;
            res.length      = byte_count + LEN_W'(1);
          end else begin
            res.event_res = EV_OVERFLOW;
            res.length    = byte_count;
          end
        end
      end
      CMD_RELEASE: begin
        res.event_slot = slot;
        if (slot_ok && slot_status[sidx] == ST_FULL) begin
          res.length             = slot_length[sidx];
          slot_status_next[sidx] = ST_FREE;
          slot_length_next[sidx] = '0;
          res.event_res          = EV_RELEASED;
        end else begin
          res.event_res = EV_REJECTED;
          if (slot_ok) begin
            res.length = slot_length[sidx];
          end
        end
      end
      CMD_READ: begin
        res.event_res  = EV_READ;
        res.event_slot = slot;
        ram_req.re     = accept;
        if (slot_ok) begin
          res.length = slot_length[sidx];
          res.rd_hit = (slot_status[sidx] == ST_FULL)
                    && (LEN_W'(offset) < slot_length[sidx])
                    && (32'(offset) < MSG_BYTES);
        end
      end
      default: begin
        res.event_res = EV_IGNORED;
      end
    endcase

    // Full mask after the step
    for (int i = 0; i < MASK_N; i++) begin
      res.full_mask[i] = (slot_status_next[i] == ST_FULL);
    end
  end

  // Commit state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_status[i] <= ST_FREE;
        slot_length[i] <= '0;
      end
      in_frame     <= 1'b0;
      current_slot <= '0;
      byte_count   <= '0;
    end else if (accept) begin
      slot_status  <= slot_status_next;
      slot_length  <= slot_length_next;
      in_frame     <= in_frame_next;
      current_slot <= current_slot_next;
      byte_count   <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nmea_sentence_framer_slot_pool_core.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence framer, slot pool core
// Path: an accepted command passes the read stage, then the output register.
// Throughput: one command per cycle unless the output stalls; the frame store
// read port sets the extra stage, and intake stops once both stages are held.
// Reset: synchronous; frees all slots and returns to waiting for '$'. The
// frame store is not cleared; reads stop at the recorded frame length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_framer_slot_pool_core
  import nsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  nsf_in_if.sink    in_ch,
  nsf_out_if.source out_ch
);

  logic              accept;
  result_t           res;
  ram_req_t          ram_req;
  logic [BYTE_W-1:0] rdata;

  logic              s1_valid;
  result_t           s1_res;
  logic              s1_move;

  logic              o_valid;
  logic [EV_W-1:0]   o_event_res;
  logic [SEL_W-1:0]  o_event_slot;
  logic [LEN_W-1:0]  o_length;
  logic [BYTE_W-1:0] o_data;
  logic [7:0]        o_full_mask;

  assign s1_move      = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s1_move;
  assign accept       = in_ch.valid && in_ch.ready;

  nsf_slot_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (in_ch.command),
    .byte_value (in_ch.byte_value),
    .slot       (in_ch.slot),
    .offset     (in_ch.offset),
    .res        (res),
    .ram_req    (ram_req)
  );

  nsf_frame_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // Read stage: wait for store data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_move) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_event_res  <= s1_res.event_res;
      o_event_slot <= s1_res.event_slot;
      o_length     <= s1_res.length;
      o_data       <= s1_res.rd_hit ? rdata : '0;
      o_full_mask  <= s1_res.full_mask;
    end
  end

  assign out_ch.valid      = o_valid;
  assign out_ch.event_res  = o_event_res;
  assign out_ch.event_slot = o_event_slot;
  assign out_ch.length     = o_length;
  assign out_ch.data       = o_data;
  assign out_ch.full_mask  = o_full_mask;

  // Held read stage must not be lost
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid)
    else $error("read stage dropped a pending event");

  // Accepted transaction reaches the read stage
  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted command did not enter the read stage");

  // Only reads carry data
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_event_res != EV_READ |-> o_data == '0)
    else $error("data set on a non-read event");

  // Completed frame shows as full
  a_complete_full: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_event_res == EV_COMPLETE |-> o_full_mask[o_event_slot])
    else $error("completed slot missing from full mask");

endmodule

`default_nettype wire
